FILE: rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the bounded deque with linear key search.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

    localparam int DQ_CAPACITY = 16;

    // request codes
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_SEARCH     = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
    } dq_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic [4:0]         position;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [4:0]         occupancy;
    } dq_rsp_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_REFILL,
        FSM_SCAN,
        FSM_EMIT
    } dq_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
    parameter int DEPTH = dq_pkg::DQ_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [31:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [31:0]   rd_data
);
    import dq_pkg::*;

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/deque_with_linear_search.sv
// ----------------------------------------------------------------------------
// deque_with_linear_search
// Bounded double-ended queue of 32-bit words kept in a ring memory, with a
// front-to-back linear key search.
//
//   channel  dir  handshake            word
//   req      in   req_valid/req_ready  dq_req_t (req_type, value)
//   rsp      out  rsp_valid/rsp_ready  dq_rsp_t (status .. occupancy)
//
// Pushes, refused requests and empty pops go from idle straight to the emit
// state. Pops that leave words behind pass through the refill state (one ring
// read to refresh the front or back copy). Search steps through the scan state,
// one ring word compared per cycle through the single read port.
// Reset empties the deque at once; ring contents are not cleared.
// A stalled rsp holds one word; the next request is taken meanwhile and
// waits in the emit state until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_linear_search #(
    parameter int CAPACITY = dq_pkg::DQ_CAPACITY
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire dq_pkg::dq_req_t  req,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output dq_pkg::dq_rsp_t       rsp
);
    import dq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // (a + b) mod CAPACITY, both operands below CAPACITY
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (AW+1)'(CAPACITY))
        begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    dq_state_t          state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic signed [31:0] front_reg, front_next;
    logic signed [31:0] back_reg, back_next;
    logic signed [31:0] key_reg, key_next;
    logic [CW-1:0]      cmp_reg, cmp_next;
    logic [AW-1:0]      scan_addr_reg, scan_addr_next;
    logic               refill_front_reg, refill_front_next;
    logic [1:0]         status_reg, status_next;
    logic signed [31:0] data_reg, data_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               rsp_valid_reg, rsp_valid_next;
    dq_rsp_t            rsp_reg, rsp_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        rd_data;

    logic               is_empty;
    logic               is_full;
    logic [AW-1:0]      head_dec;
    logic [AW-1:0]      head_inc;

    dq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg >= CW'(CAPACITY));
    assign head_inc = wrap_add(head_reg, AW'(1));
    assign head_dec = (head_reg == '0) ? AW'(CAPACITY - 1) : head_reg - AW'(1);

    assign req_ready = (state_reg == FSM_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg        <= front_next;
        back_reg         <= back_next;
        key_reg          <= key_next;
        cmp_reg          <= cmp_next;
        scan_addr_reg    <= scan_addr_next;
        refill_front_reg <= refill_front_next;
        status_reg       <= status_next;
        data_reg         <= data_next;
        pos_reg          <= pos_next;
        rsp_reg          <= rsp_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        front_next        = front_reg;
        back_next         = back_reg;
        key_next          = key_reg;
        cmp_next          = cmp_reg;
        scan_addr_next    = scan_addr_reg;
        refill_front_next = refill_front_reg;
        status_next       = status_reg;
        data_next         = data_reg;
        pos_next          = pos_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;
        wr_en             = 1'b0;
        wr_addr           = head_reg;
        rd_en             = 1'b0;
        rd_addr           = scan_addr_reg;

        case (state_reg)
            FSM_IDLE:
            begin
                if (req_valid)
                begin
                    status_next = ST_OK;
                    data_next   = '0;
                    pos_next    = '0;
                    state_next  = FSM_EMIT;
                    case (req.req_type)
                        REQ_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = wrap_add(head_reg, count_reg[AW-1:0]);
                                count_next = count_reg + CW'(1);
                                back_next  = req.value;
                                if (is_empty)
                                begin
                                    front_next = req.value;
                                end
                            end
                        end
                        REQ_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = head_dec;
                                head_next  = head_dec;
                                count_next = count_reg + CW'(1);
                                front_next = req.value;
                                if (is_empty)
                                begin
                                    back_next = req.value;
                                end
                            end
                        end
                        REQ_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                data_next  = front_reg;
                                head_next  = head_inc;
                                count_next = count_reg - CW'(1);
                                if (count_reg != CW'(1))
                                begin
                                    rd_en             = 1'b1;
                                    rd_addr           = head_inc;
                                    refill_front_next = 1'b1;
                                    state_next        = FSM_REFILL;
                                end
                            end
                        end
                        REQ_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                data_next  = back_reg;
                                count_next = count_reg - CW'(1);
                                if (count_reg != CW'(1))
                                begin
                                    rd_en             = 1'b1;
                                    rd_addr           = wrap_add(head_reg,
                                                        AW'(count_reg - CW'(2)));
                                    refill_front_next = 1'b0;
                                    state_next        = FSM_REFILL;
                                end
                            end
                        end
                        REQ_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                key_next       = req.value;
                                rd_en          = 1'b1;
                                rd_addr        = head_reg;
                                scan_addr_next = head_inc;
                                cmp_next       = '0;
                                state_next     = FSM_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            FSM_REFILL:
            begin
                if (refill_front_reg)
                begin
                    front_next = rd_data;
                end
                else
                begin
                    back_next = rd_data;
                end
                state_next = FSM_EMIT;
            end

            FSM_SCAN:
            begin
                // rd_data holds the word at offset cmp_reg from the head
                if (rd_data == key_reg)
                begin
                    status_next = ST_OK;
                    pos_next    = cmp_reg + CW'(1);
                    state_next  = FSM_EMIT;
                end
                else if (cmp_reg + CW'(1) == count_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = FSM_EMIT;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_addr_reg;
                    scan_addr_next = wrap_add(scan_addr_reg, AW'(1));
                    cmp_next       = cmp_reg + CW'(1);
                end
            end

            FSM_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.data_out    = data_reg;
                    rsp_next.position    = 5'(pos_reg);
                    rsp_next.front_value = is_empty ? '0 : front_reg;
                    rsp_next.back_value  = is_empty ? '0 : back_reg;
                    rsp_next.occupancy   = 5'(count_reg);
                    state_next           = FSM_IDLE;
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < AW'(CAPACITY - 1) || head_reg == AW'(CAPACITY - 1))
        else $error("head index out of ring");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FSM_SCAN |-> cmp_reg < count_reg)
        else $error("search ran past the stored words");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.req_type == REQ_PUSH_BACK && !is_full)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not grow the deque");

endmodule

`default_nettype wire
